[rtl/smcn_pkg.sv]
// shared types and constants for the sensor min/max calibrate and normalise core
package smcn_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CH_BITS     = 3;
    localparam int NORM_BITS   = 16;
    localparam int QUO_STEPS   = 15;

    localparam logic [NORM_BITS-1:0] Q_ONE = NORM_BITS'(1) << QUO_STEPS;

    localparam logic [1:0] REQ_TRACK  = 2'd0;
    localparam logic [1:0] REQ_COMMIT = 2'd1;
    localparam logic [1:0] REQ_NORM   = 2'd2;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [CH_BITS-1:0]     channel;
        logic [SAMPLE_BITS-1:0] sample;
    } req_item_t;

    typedef struct packed {
        logic [NORM_BITS-1:0] norm_value;
        logic                 norm_valid;
    } rsp_item_t;

    typedef struct packed {
        logic                   max_we;
        logic                   min_we;
        logic                   cal_we;
        logic [SAMPLE_BITS-1:0] sample;
        logic [SAMPLE_BITS-1:0] range;
    } store_wr_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] trk_min;
        logic [SAMPLE_BITS-1:0] trk_max;
        logic [SAMPLE_BITS-1:0] cal_min;
        logic [SAMPLE_BITS-1:0] cal_range;
    } store_rd_t;

endpackage

[rtl/smcn_store.sv]
// per-channel tracked and calibrated values with one shared read index
module smcn_store #(
    parameter int CHANNELS = 8,
    parameter int IDX_W    = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IDX_W-1:0]       idx,
    input  smcn_pkg::store_wr_t    wr,
    output smcn_pkg::store_rd_t    rd
);

    localparam int SB = smcn_pkg::SAMPLE_BITS;

    logic [SB-1:0] trk_min_reg   [CHANNELS];
    logic [SB-1:0] trk_max_reg   [CHANNELS];
    logic [SB-1:0] cal_min_reg   [CHANNELS];
    logic [SB-1:0] cal_range_reg [CHANNELS];

    always_comb
    begin
        rd.trk_min   = trk_min_reg[idx];
        rd.trk_max   = trk_max_reg[idx];
        rd.cal_min   = cal_min_reg[idx];
        rd.cal_range = cal_range_reg[idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                trk_min_reg[i]   <= '1;
                trk_max_reg[i]   <= '0;
                cal_min_reg[i]   <= '0;
                cal_range_reg[i] <= SB'(1);
            end
        end
        else
        begin
            if (wr.max_we)
            begin
                trk_max_reg[idx] <= wr.sample;
            end
            if (wr.min_we)
            begin
                trk_min_reg[idx] <= wr.sample;
            end
            if (wr.cal_we)
            begin
                cal_min_reg[idx]   <= trk_min_reg[idx];
                cal_range_reg[idx] <= wr.range;
            end
        end
    end

endmodule

[rtl/sensor_minmax_calibrate_normalize_core.sv]
// top level: request sequencer, shared subtractor, restoring divider and result register
//
// Requests arrive on req/req_valid/req_stall, results leave on rsp/rsp_valid/rsp_stall.
// A transfer happens at a rising edge with valid high and stall low. Every request
// yields exactly one result.
// Track folds a sample into its channel's min and max, in state TRK_MAX and then TRK_MIN.
// Commit copies min and range for every channel, one channel per cycle.
// Normalise: the result is 0 or 1.0 from the subtract and compare states; otherwise it is set
// by the 15 quotient bits of the bit-serial divider that shares the single subtractor.
// Unused request types and out-of-range channels give a zero result.
// One request is in flight at a time; req_stall is high while it is worked on.
// The result register lets a new request be taken while an earlier result waits;
// a stalled result holds, and a finished request waits for the register to free.
// Reset clears all channels at once: tracked min to full scale, tracked max 0,
// calibrated min 0, range 1. There is no clearing pass.
module sensor_minmax_calibrate_normalize_core #(
    parameter int CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  smcn_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output smcn_pkg::rsp_item_t rsp
);

    localparam int SB    = smcn_pkg::SAMPLE_BITS;
    localparam int NB    = smcn_pkg::NORM_BITS;
    localparam int QS    = smcn_pkg::QUO_STEPS;
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STP_W = $clog2(QS);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_TRK_MAX = 8'b0000_0010,
        S_TRK_MIN = 8'b0000_0100,
        S_COMMIT  = 8'b0000_1000,
        S_NRM_SUB = 8'b0001_0000,
        S_NRM_CMP = 8'b0010_0000,
        S_DIV     = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SB-1:0]       smp_reg, smp_next;
    logic [SB-1:0]       rem_reg, rem_next;
    logic [QS-1:0]       quo_reg, quo_next;
    logic [STP_W-1:0]    step_reg, step_next;
    logic [NB-1:0]       res_reg, res_next;
    logic                res_vld_reg, res_vld_next;
    logic                rsp_valid_reg, rsp_valid_next;
    smcn_pkg::rsp_item_t rsp_reg, rsp_next;

    smcn_pkg::store_wr_t wr;
    smcn_pkg::store_rd_t rd;

    logic [SB:0]   sub_a;
    logic [SB:0]   sub_b;
    logic [SB+1:0] sub_diff;
    logic          borrow;
    logic          diff_zero;
    logic          accept;
    logic          ch_ok;
    logic          out_free;

    smcn_store #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (idx_reg),
        .wr    (wr),
        .rd    (rd)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign ch_ok     = (int'(req.channel) < CHANNELS);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // shared subtract and compare unit
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            S_TRK_MAX:
            begin
                sub_a = {1'b0, rd.trk_max};
                sub_b = {1'b0, smp_reg};
            end
            S_TRK_MIN:
            begin
                sub_a = {1'b0, smp_reg};
                sub_b = {1'b0, rd.trk_min};
            end
            S_COMMIT:
            begin
                sub_a = {1'b0, rd.trk_max};
                sub_b = {1'b0, rd.trk_min};
            end
            S_NRM_SUB:
            begin
                sub_a = {1'b0, smp_reg};
                sub_b = {1'b0, rd.cal_min};
            end
            S_NRM_CMP:
            begin
                sub_a = {1'b0, rem_reg};
                sub_b = {1'b0, rd.cal_range};
            end
            S_DIV:
            begin
                sub_a = {rem_reg, 1'b0};
                sub_b = {1'b0, rd.cal_range};
            end
            S_IDLE, S_DONE:
            begin
                sub_a = '0;
                sub_b = '0;
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff  = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow    = sub_diff[SB+1];
    assign diff_zero = (sub_diff[SB:0] == '0);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        smp_next       = smp_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        res_vld_next   = res_vld_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr             = '0;
        wr.sample      = smp_reg;
        wr.range       = (!borrow && !diff_zero) ? sub_diff[SB-1:0] : SB'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    smp_next     = req.sample;
                    idx_next     = IDX_W'(req.channel);
                    res_next     = '0;
                    res_vld_next = 1'b0;
                    priority if (req.req_type == smcn_pkg::REQ_TRACK && ch_ok)
                    begin
                        state_next = S_TRK_MAX;
                    end
                    else if (req.req_type == smcn_pkg::REQ_COMMIT)
                    begin
                        idx_next   = '0;
                        state_next = S_COMMIT;
                    end
                    else if (req.req_type == smcn_pkg::REQ_NORM && ch_ok)
                    begin
                        res_vld_next = 1'b1;
                        state_next   = S_NRM_SUB;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_TRK_MAX:
            begin
                wr.max_we  = borrow;
                state_next = S_TRK_MIN;
            end
            S_TRK_MIN:
            begin
                wr.min_we  = borrow;
                state_next = S_DONE;
            end
            S_COMMIT:
            begin
                wr.cal_we = 1'b1;
                if (idx_reg == IDX_W'(CHANNELS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_NRM_SUB:
            begin
                rem_next = sub_diff[SB-1:0];
                if (borrow || diff_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NRM_CMP;
                end
            end
            S_NRM_CMP:
            begin
                step_next = STP_W'(QS - 1);
                quo_next  = '0;
                if (!borrow)
                begin
                    res_next   = smcn_pkg::Q_ONE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                quo_next = {quo_reg[QS-2:0], ~borrow};
                if (!borrow)
                begin
                    rem_next = sub_diff[SB-1:0];
                end
                else
                begin
                    rem_next = sub_a[SB-1:0];
                end
                if (step_reg == '0)
                begin
                    res_next   = NB'({quo_reg[QS-2:0], ~borrow});
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg - STP_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_next.norm_value = res_reg;
                    rsp_next.norm_valid = res_vld_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        smp_reg     <= smp_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
        res_reg     <= res_next;
        res_vld_reg <= res_vld_next;
        rsp_reg     <= rsp_next;
    end

endmodule
